/* design/tpsa_pkg.sv */
package tpsa_pkg;

  typedef enum logic [2:0] {
    OP_START    = 3'd0,
    OP_RESTART  = 3'd1,
    OP_STOP     = 3'd2,
    OP_SHUTDOWN = 3'd3,
    OP_TICK     = 3'd4,
    OP_QUERY    = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    EV_ACK       = 3'd0,
    EV_START     = 3'd1,
    EV_STOP      = 3'd2,
    EV_ERROR     = 3'd3,
    EV_TICK_DONE = 3'd4
  } event_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_LT  = 1'b1
  } alu_mode_e;

  localparam int unsigned TimeW = 32;
  localparam int unsigned DurW  = 24;
  localparam int unsigned IdW   = 5;

endpackage

/* design/tpsa_alu.sv */
module tpsa_alu
  import tpsa_pkg::*;
(
  input  logic [TimeW-1:0] a_i,
  input  logic [TimeW-1:0] b_i,
  input  alu_mode_e        mode_i,
  output logic [TimeW-1:0] sum_o,
  output logic             lt_o
);

  logic [TimeW-1:0] b_op;
  logic [TimeW:0]   res;

  // compare as a + ~b + 1, no carry out means a < b
  assign b_op  = (mode_i == ALU_LT) ? ~b_i : b_i;
  assign res   = {1'b0, a_i} + {1'b0, b_op} + (TimeW + 1)'(mode_i == ALU_LT);
  assign sum_o = res[TimeW-1:0];
  assign lt_o  = ~res[TimeW];

endmodule

/* design/timer_pool_with_slot_allocation.sv */
// channel   | direction | tdata (low bit up)                          | tuser     | tlast
// s_axis    | in        | slot[4:0] duration[28:5] repeat_req[29]     | op[2:0]   | -
// m_axis    | out       | slot_id[4:0] ok[5] active[6] free_count[11:7] | event_res | last
//
// restart, stop, shutdown, query and bad ops go from S_EXEC straight to the result beat.
// start searches one slot a cycle to the lowest free slot, or all when full, plus the beat.
// tick: steps the clock in the shared adder, reads and compares each slot's deadline in it,
// then an event pass sends a beat per expired or active repeating slot and a last beat.
// reset clears the clock, active and repeat flags; deadlines hold garbage until written.
// one item at a time: s_axis_tready_o is low until the last result beat is taken.
module timer_pool_with_slot_allocation
  import tpsa_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // slot, duration, repeat_req
  input  logic [2:0]  s_axis_tuser_i,  // op
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // slot_id, ok, active, free_count
  output logic [2:0]  m_axis_tuser_o,  // event_res
  output logic        m_axis_tlast_o   // last
);

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(NUM_SLOTS + 1);
  localparam logic [IdW-1:0] NoneId = IdW'(NUM_SLOTS);
  localparam logic [CntW-1:0] LastIdx = CntW'(NUM_SLOTS - 1);
  localparam logic [CntW-1:0] EndIdx = CntW'(NUM_SLOTS);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_EXEC     = 7'b0000010,
    S_FIND     = 7'b0000100,
    S_SCAN_RD  = 7'b0001000,
    S_SCAN_CMP = 7'b0010000,
    S_EMIT     = 7'b0100000,
    S_OUT      = 7'b1000000
  } state_e;

  state_e                state_q, state_d;
  logic [2:0]            op_q, op_d;
  logic [IdW-1:0]        slot_q, slot_d;
  logic [DurW-1:0]       dur_q, dur_d;
  logic                  req_rep_q, req_rep_d;
  logic [CntW-1:0]       idx_q, idx_d;
  logic [CntW-1:0]       free_q, free_d;
  logic [TimeW-1:0]      now_q, now_d;
  logic [NUM_SLOTS-1:0]  active_q, active_d;
  logic [NUM_SLOTS-1:0]  rpt_q, rpt_d;
  logic [NUM_SLOTS-1:0]  exp_q, exp_d;
  logic [2:0]            ev_q, ev_d;
  logic [IdW-1:0]        sid_q, sid_d;
  logic                  ok_q, ok_d;
  logic                  act_q, act_d;
  logic                  last_q, last_d;

  logic [TimeW-1:0]      deadline_mem [NUM_SLOTS];
  logic [TimeW-1:0]      rd_q;
  logic                  mem_we;
  logic [IdxW-1:0]       mem_waddr;

  logic [TimeW-1:0]      alu_a, alu_b, alu_sum;
  alu_mode_e             alu_mode;
  logic                  alu_lt;

  logic [IdxW-1:0]       fidx, sidx;
  logic                  slot_ok;
  logic                  in_fire;

  assign fidx    = idx_q[IdxW-1:0];
  assign sidx    = IdxW'(slot_q);
  assign slot_ok = (32'(slot_q) < NUM_SLOTS);
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  tpsa_alu u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .mode_i (alu_mode),
    .sum_o  (alu_sum),
    .lt_o   (alu_lt)
  );

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    slot_d    = slot_q;
    dur_d     = dur_q;
    req_rep_d = req_rep_q;
    idx_d     = idx_q;
    free_d    = free_q;
    now_d     = now_q;
    active_d  = active_q;
    rpt_d     = rpt_q;
    exp_d     = exp_q;
    ev_d      = ev_q;
    sid_d     = sid_q;
    ok_d      = ok_q;
    act_d     = act_q;
    last_d    = last_q;
    mem_we    = 1'b0;
    mem_waddr = fidx;
    alu_a     = now_q;
    alu_b     = TimeW'(dur_q);
    alu_mode  = ALU_ADD;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d      = s_axis_tuser_i;
          slot_d    = s_axis_tdata_i[4:0];
          dur_d     = s_axis_tdata_i[28:5];
          req_rep_d = s_axis_tdata_i[29];
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        ev_d    = EV_ERROR;
        sid_d   = NoneId;
        ok_d    = 1'b0;
        act_d   = 1'b0;
        last_d  = 1'b1;
        state_d = S_OUT;
        case (op_q)
          OP_START: begin
            idx_d   = '0;
            state_d = S_FIND;
          end
          OP_RESTART: begin
            if (slot_ok) begin
              mem_we         = 1'b1;
              mem_waddr      = sidx;
              active_d[sidx] = 1'b1;
              if (!active_q[sidx]) begin
                free_d = free_q - 1'b1;
              end
              ev_d  = EV_ACK;
              sid_d = slot_q;
              ok_d  = 1'b1;
            end
          end
          OP_STOP, OP_SHUTDOWN: begin
            if (slot_ok) begin
              active_d[sidx] = 1'b0;
              if (active_q[sidx]) begin
                free_d = free_q + 1'b1;
              end
              ev_d  = (op_q == OP_STOP) ? EV_STOP : EV_ACK;
              sid_d = slot_q;
              ok_d  = 1'b1;
            end
          end
          OP_QUERY: begin
            if (slot_ok) begin
              ev_d  = EV_ACK;
              sid_d = slot_q;
              ok_d  = 1'b1;
              act_d = active_q[sidx];
            end
          end
          OP_TICK: begin
            alu_b   = TimeW'(1);
            now_d   = alu_sum;
            idx_d   = '0;
            exp_d   = '0;
            state_d = S_SCAN_RD;
          end
          default: begin
            state_d = S_OUT;
          end
        endcase
      end
      S_FIND: begin
        if (!active_q[fidx]) begin
          mem_we         = 1'b1;
          active_d[fidx] = 1'b1;
          rpt_d[fidx]    = req_rep_q;
          free_d         = free_q - 1'b1;
          ev_d           = EV_START;
          sid_d          = IdW'(idx_q);
          ok_d           = 1'b1;
          act_d          = 1'b0;
          last_d         = 1'b1;
          state_d        = S_OUT;
        end else if (idx_q == LastIdx) begin
          ev_d    = EV_ERROR;
          sid_d   = NoneId;
          ok_d    = 1'b0;
          act_d   = 1'b0;
          last_d  = 1'b1;
          state_d = S_OUT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        alu_a    = rd_q;
        alu_b    = now_q;
        alu_mode = ALU_LT;
        if (active_q[fidx] && alu_lt) begin
          active_d[fidx] = 1'b0;
          exp_d[fidx]    = 1'b1;
          free_d         = free_q + 1'b1;
        end
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          state_d = S_EMIT;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_SCAN_RD;
        end
      end
      S_EMIT: begin
        ok_d  = 1'b1;
        act_d = 1'b0;
        if (idx_q == EndIdx) begin
          ev_d    = EV_TICK_DONE;
          sid_d   = NoneId;
          last_d  = 1'b1;
          state_d = S_OUT;
        end else if (exp_q[fidx]) begin
          ev_d    = EV_STOP;
          sid_d   = IdW'(idx_q);
          last_d  = 1'b0;
          state_d = S_OUT;
        end else if (active_q[fidx] && rpt_q[fidx]) begin
          ev_d    = EV_START;
          sid_d   = IdW'(idx_q);
          last_d  = 1'b0;
          state_d = S_OUT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_OUT: begin
        if (m_axis_tready_i) begin
          if (last_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_EMIT;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      free_q   <= CntW'(NUM_SLOTS);
      now_q    <= '0;
      active_q <= '0;
      rpt_q    <= '0;
      exp_q    <= '0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      free_q   <= free_d;
      now_q    <= now_d;
      active_q <= active_d;
      rpt_q    <= rpt_d;
      exp_q    <= exp_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    slot_q    <= slot_d;
    dur_q     <= dur_d;
    req_rep_q <= req_rep_d;
    ev_q      <= ev_d;
    sid_q     <= sid_d;
    ok_q      <= ok_d;
    act_q     <= act_d;
  end

  // deadline store, registered read port follows the scan index
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      deadline_mem[mem_waddr] <= alu_sum;
    end
    rd_q <= deadline_mem[fidx];
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_OUT);
  assign m_axis_tuser_o  = ev_q;
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tdata_o  = {4'b0, IdW'(free_q), act_q, ok_q, sid_q};

endmodule
